// File: hw/rtl/vtpe_pkg.sv
package vtpe_pkg;

	// byte slots of one queued command, in the order they go out
	localparam int SLOTS = 9;
	localparam int SLOT_HI_Y = 4;
	localparam int SLOT_EXTRA = 5;
	localparam int SLOT_LO_Y = 6;
	localparam int SLOT_HI_X = 7;
	localparam int SLOT_LO_X = 8;

	// command queue between front and back, power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;

	localparam logic signed [13:0] JUMP_LIMIT = 14'sd1500;
	localparam logic [7:0] INTEN_MIN = 8'd32;
	localparam logic [7:0] INTEN_MAX = 8'd125;

	localparam logic [7:0] B_NUL = 8'h00;
	localparam logic [7:0] B_FF = 8'h0C;
	localparam logic [7:0] B_ESC = 8'h1B;
	localparam logic [7:0] B_FS = 8'h1C;
	localparam logic [7:0] B_GS = 8'h1D;
	localparam logic [7:0] B_US = 8'h1F;

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_VECTOR,
		MODE_POINT,
		MODE_IPOINT
	} mode_t;

	typedef enum logic [2:0] {
		ACT_DRAW,
		ACT_MOVE,
		ACT_POINT,
		ACT_IPOINT,
		ACT_TEXT,
		ACT_PAGE
	} act_t;

	typedef struct packed {
		logic [SLOTS-1:0][7:0] data;
		logic [SLOTS-1:0]      mask;
	} entry_t;

endpackage

// File: hw/rtl/vtpe_front.sv
module vtpe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [vtpe_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [vtpe_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                          q_full,
	output logic                          q_push,
	output vtpe_pkg::entry_t              q_entry
);

	logic               jump_en_q;
	vtpe_pkg::mode_t    mode_q, mode_n;
	logic [6:0]         sent_hi_y_q, sent_lo_y_q, sent_hi_x_q, sent_extra_q;
	logic [6:0]         sent_hi_y_n, sent_lo_y_n, sent_hi_x_n, sent_extra_n;
	logic signed [12:0] prev_x_q, prev_y_q, prev_x_n, prev_y_n;

	logic [7:0]         inten;
	logic [13:0]        x_in, y_in;
	logic               in_range, plot_ok, accept;
	logic [7:0]         lo_x, hi_x, lo_y, hi_y, extra, inten_c;
	logic signed [13:0] dx, dy;
	logic               jump;

	assign inten = s_tdata[7:0];
	assign x_in = s_tdata[21:8];
	assign y_in = s_tdata[35:22];
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	assign in_range = (x_in[13:12] == 2'b00) && (y_in[13:12] == 2'b00);

	assign lo_x = {3'b010, x_in[6:2]};
	assign hi_x = {3'b001, x_in[11:7]};
	assign lo_y = {3'b011, y_in[6:2]};
	assign hi_y = {3'b001, y_in[11:7]};
	assign extra = {4'b0110, y_in[1:0], x_in[1:0]};

	assign inten_c = (inten > vtpe_pkg::INTEN_MAX) ? vtpe_pkg::INTEN_MAX :
		(inten < vtpe_pkg::INTEN_MIN) ? vtpe_pkg::INTEN_MIN : inten;

	assign dx = $signed({2'b00, x_in[11:0]}) - $signed({prev_x_q[12], prev_x_q});
	assign dy = $signed({2'b00, y_in[11:0]}) - $signed({prev_y_q[12], prev_y_q});
	assign jump = (dx > vtpe_pkg::JUMP_LIMIT) || (dx < -vtpe_pkg::JUMP_LIMIT) ||
		(dy > vtpe_pkg::JUMP_LIMIT) || (dy < -vtpe_pkg::JUMP_LIMIT);

	always_comb begin
		q_entry = '0;
		plot_ok = 1'b0;
		mode_n = mode_q;
		sent_hi_y_n = sent_hi_y_q;
		sent_lo_y_n = sent_lo_y_q;
		sent_hi_x_n = sent_hi_x_q;
		sent_extra_n = sent_extra_q;
		prev_x_n = prev_x_q;
		prev_y_n = prev_y_q;
		case (vtpe_pkg::act_t'(s_tuser))
			vtpe_pkg::ACT_DRAW: begin
				plot_ok = in_range;
			end
			vtpe_pkg::ACT_MOVE: begin
				plot_ok = in_range;
				if (in_range) begin
					if (mode_q == vtpe_pkg::MODE_POINT || mode_q == vtpe_pkg::MODE_IPOINT) begin
						q_entry.data[2] = vtpe_pkg::B_US;
						q_entry.mask[2] = 1'b1;
					end
					q_entry.data[3] = vtpe_pkg::B_GS;
					q_entry.mask[3] = 1'b1;
					mode_n = vtpe_pkg::MODE_VECTOR;
				end
			end
			vtpe_pkg::ACT_POINT: begin
				plot_ok = in_range;
				if (in_range) begin
					if (mode_q != vtpe_pkg::MODE_POINT) begin
						q_entry.data[3] = vtpe_pkg::B_FS;
						q_entry.mask[3] = 1'b1;
					end
					mode_n = vtpe_pkg::MODE_POINT;
				end
			end
			vtpe_pkg::ACT_IPOINT: begin
				plot_ok = in_range;
				if (in_range) begin
					if (mode_q != vtpe_pkg::MODE_IPOINT) begin
						q_entry.data[0] = vtpe_pkg::B_US;
						q_entry.mask[0] = (mode_q != vtpe_pkg::MODE_TEXT);
						q_entry.data[1] = vtpe_pkg::B_ESC;
						q_entry.mask[1] = 1'b1;
						q_entry.data[2] = vtpe_pkg::B_FS;
						q_entry.mask[2] = 1'b1;
					end
					q_entry.data[3] = inten_c;
					q_entry.mask[3] = 1'b1;
					mode_n = vtpe_pkg::MODE_IPOINT;
				end
			end
			vtpe_pkg::ACT_TEXT: begin
				for (int i = 0; i < 4; i++) begin
					q_entry.data[i] = vtpe_pkg::B_NUL;
					q_entry.mask[i] = jump_en_q && (mode_q == vtpe_pkg::MODE_VECTOR);
				end
				q_entry.data[4] = vtpe_pkg::B_US;
				q_entry.mask[4] = 1'b1;
				mode_n = vtpe_pkg::MODE_TEXT;
				prev_x_n = '1;
				prev_y_n = '1;
			end
			vtpe_pkg::ACT_PAGE: begin
				q_entry.data[0] = vtpe_pkg::B_ESC;
				q_entry.mask[0] = 1'b1;
				q_entry.data[1] = vtpe_pkg::B_FF;
				q_entry.mask[1] = 1'b1;
				mode_n = vtpe_pkg::MODE_TEXT;
				sent_hi_y_n = '0;
				sent_lo_y_n = '0;
				sent_hi_x_n = '0;
				sent_extra_n = '0;
				prev_x_n = '1;
				prev_y_n = '1;
			end
			default: begin
				q_entry = '0;
			end
		endcase

		if (plot_ok) begin
			// a new hi x rewrites the lo y slot, so lo y goes out with it
			q_entry.data[vtpe_pkg::SLOT_HI_Y] = hi_y;
			q_entry.mask[vtpe_pkg::SLOT_HI_Y] = (sent_hi_y_q != hi_y[6:0]);
			q_entry.data[vtpe_pkg::SLOT_EXTRA] = extra;
			q_entry.mask[vtpe_pkg::SLOT_EXTRA] = (sent_extra_q != extra[6:0]);
			q_entry.data[vtpe_pkg::SLOT_LO_Y] = lo_y;
			q_entry.mask[vtpe_pkg::SLOT_LO_Y] = (sent_extra_q != extra[6:0]) ||
				(((sent_hi_x_q != hi_x[6:0]) ? hi_x[6:0] : sent_lo_y_q) != lo_y[6:0]);
			q_entry.data[vtpe_pkg::SLOT_HI_X] = hi_x;
			q_entry.mask[vtpe_pkg::SLOT_HI_X] = (sent_hi_x_q != hi_x[6:0]);
			q_entry.data[vtpe_pkg::SLOT_LO_X] = lo_x;
			q_entry.mask[vtpe_pkg::SLOT_LO_X] = 1'b1;
			sent_hi_y_n = hi_y[6:0];
			sent_lo_y_n = lo_y[6:0];
			sent_hi_x_n = hi_x[6:0];
			sent_extra_n = extra[6:0];
			if (jump_en_q) begin
				if (jump && mode_n == vtpe_pkg::MODE_VECTOR) begin
					sent_hi_y_n = '0;
					sent_lo_y_n = '0;
					sent_hi_x_n = '0;
					sent_extra_n = '0;
				end
				prev_x_n = $signed({1'b0, x_in[11:0]});
				prev_y_n = $signed({1'b0, y_in[11:0]});
			end
		end
	end

	assign q_push = accept && (q_entry.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_en_q <= 1'b0;
		end else if (cfg_wen) begin
			jump_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= vtpe_pkg::MODE_TEXT;
			sent_hi_y_q <= '0;
			sent_lo_y_q <= '0;
			sent_hi_x_q <= '0;
			sent_extra_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			sent_hi_y_q <= sent_hi_y_n;
			sent_lo_y_q <= sent_lo_y_n;
			sent_hi_x_q <= sent_hi_x_n;
			sent_extra_q <= sent_extra_n;
			prev_x_q <= prev_x_n;
			prev_y_q <= prev_y_n;
		end
	end

endmodule

// File: hw/rtl/vtpe_queue.sv
module vtpe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vtpe_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output vtpe_pkg::entry_t head,
	output logic             empty
);

	vtpe_pkg::entry_t                entries_q [vtpe_pkg::QDEPTH];
	logic [vtpe_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [vtpe_pkg::QPTR_W:0]       count_q;

	assign full = (count_q == (vtpe_pkg::QPTR_W+1)'(vtpe_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/vtpe_back.sv
module vtpe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  vtpe_pkg::entry_t head,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);

	logic [vtpe_pkg::SLOTS-1:0][7:0] cur_data_q;
	logic [vtpe_pkg::SLOTS-1:0]      cur_mask_q;
	logic                            out_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            out_last_q;

	logic                            advance, use_head, have_src;
	logic [vtpe_pkg::SLOTS-1:0][7:0] src_data;
	logic [vtpe_pkg::SLOTS-1:0]      src_mask, low_bit, remain;
	logic [7:0]                      pick;

	assign advance = !out_valid_q || m_tready;
	assign use_head = (cur_mask_q == '0);
	assign have_src = !use_head || !q_empty;
	assign src_data = use_head ? head.data : cur_data_q;
	assign src_mask = use_head ? head.mask : cur_mask_q;
	assign low_bit = src_mask & (~src_mask + 1'b1);
	assign remain = src_mask & ~low_bit;
	assign q_pop = advance && use_head && !q_empty;

	always_comb begin
		pick = '0;
		for (int i = 0; i < vtpe_pkg::SLOTS; i++) begin
			pick = pick | (src_data[i] & {8{low_bit[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_data_q <= head.data;
		end
		if (advance && have_src) begin
			out_byte_q <= pick;
			out_last_q <= (remain == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= have_src;
			if (have_src) begin
				cur_mask_q <= remain;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_last_q;

endmodule

// File: hw/rtl/vector_terminal_plot_encoder.sv
// the first byte of a command passes the command queue and then the output register before it shows on m_tvalid
// output: one byte per cycle while m_tready is high and a command is waiting; a command emits 1 to 9 bytes
// input side takes a word every cycle while the 4-entry command queue has room
// out-of-range points and unused action codes are taken and produce no bytes
// reset (arst_n low, asynchronous): text mode, sent-address memory and previous point
// cleared, jump reset disabled, queue and output register emptied
module vector_terminal_plot_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	// jump reset enable register
	input  logic                           cfg_wen,
	input  logic                           cfg_wdata,
	// plot commands
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// intensity[7:0], x_coord[21:8], y_coord[35:22], zero fill [39:36]
	input  logic [vtpe_pkg::S_TDATA_W-1:0] s_tdata,
	// action[2:0]
	input  logic [vtpe_pkg::S_TUSER_W-1:0] s_tuser,
	// terminal byte stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_byte[7:0]
	output logic [7:0]                     m_tdata,
	// last byte of a command
	output logic                           m_tlast
);

	logic             q_push, q_full, q_pop, q_empty;
	vtpe_pkg::entry_t q_entry, q_head;

	// front: decode each word, track mode and sent address bytes, build the byte list
	vtpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	// short queue of pending byte lists so front and back stall on their own
	vtpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	// back: serialize one byte per cycle, unless m_tready stalls it, into the output register, flag the last one
	vtpe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hw/rtl/vtpe_checker.sv
module vtpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// input only backs up when bytes are waiting on the output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with output empty");

	// ESC inside a command is followed at once by FS or FF
	a_esc_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata == vtpe_pkg::B_ESC && !m_tlast
		|=> m_tvalid && (m_tdata == vtpe_pkg::B_FS || m_tdata == vtpe_pkg::B_FF))
		else $error("ESC not followed by FS or FF");

	// a command ends in lo x, US or FF
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:5] == 3'b010 ||
			m_tdata == vtpe_pkg::B_US || m_tdata == vtpe_pkg::B_FF)
		else $error("unexpected final byte");

endmodule

bind vector_terminal_plot_encoder vtpe_checker u_vtpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: bench/vector_terminal_plot_encoder_tb.sv
module vector_terminal_plot_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// action codes the block takes and drops without a byte
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;

	localparam int COORD_MAX = 4095;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD = 300;
	localparam int TIMEOUT_NS = 2_000_000;

	// one plot command as it sits on the slave side
	typedef struct packed {
		logic [2:0]         act;
		logic [7:0]         level;
		logic signed [13:0] x;
		logic signed [13:0] y;
	} plot_cmd_t;

	// one terminal byte with its end-of-command flag
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} term_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic cfg_wdata = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// intensity[7:0], x_coord[21:8], y_coord[35:22], zero fill [39:36]
	logic [vtpe_pkg::S_TDATA_W-1:0] s_tdata = '0;
	// action[2:0]
	logic [vtpe_pkg::S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// out_byte[7:0]
	logic [7:0] m_tdata;
	logic m_tlast;

	vector_terminal_plot_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// commands waiting to go out, and the byte stream they should produce
	plot_cmd_t pending_cmds[$];
	term_byte_t expected_bytes[$];

	// idle percentages for each side, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// long receiver hold-offs: asked by the sequencer, counted by the receiver
	int long_holds_asked = 0;
	int long_holds_done = 0;
	int hold_left = 0;

	int errors = 0;

	// walk position for the random commands
	int walk_x = 2048;
	int walk_y = 2048;

	// encoder state as the terminal sees it
	bit jump_en = 1'b0;
	vtpe_pkg::mode_t term_mode = vtpe_pkg::MODE_TEXT;
	logic [6:0] sent_hy = '0;
	logic [6:0] sent_ly = '0;
	logic [6:0] sent_hx = '0;
	logic [6:0] sent_ex = '0;
	logic signed [12:0] prev_x = '0;
	logic signed [12:0] prev_y = '0;

	function automatic int abs_diff(int a, int b);
		return a > b ? a - b : b - a;
	endfunction

	// works out the bytes one accepted command gives and queues them
	task automatic encode_command(input plot_cmd_t c);
		logic [7:0] bytes[$];
		int x, y;
		logic [7:0] level;
		logic [6:0] lo_x, hi_x, lo_y, hi_y, extra;
		bit snd_hx, snd_ex, snd_ly, snd_hy;
		term_byte_t tb;
		x = int'($signed(c.x));
		y = int'($signed(c.y));
		level = c.level;
		snd_hx = 0;
		snd_ex = 0;
		snd_ly = 0;
		snd_hy = 0;
		if (c.act == vtpe_pkg::ACT_DRAW || c.act == vtpe_pkg::ACT_MOVE ||
				c.act == vtpe_pkg::ACT_POINT || c.act == vtpe_pkg::ACT_IPOINT) begin
			// off-screen points are swallowed with no state change
			if (x < 0 || x > COORD_MAX || y < 0 || y > COORD_MAX)
				return;
			// mode prefix
			if (c.act == vtpe_pkg::ACT_MOVE) begin
				if (term_mode != vtpe_pkg::MODE_VECTOR && term_mode != vtpe_pkg::MODE_TEXT)
					bytes.push_back(vtpe_pkg::B_US);
				bytes.push_back(vtpe_pkg::B_GS);
				term_mode = vtpe_pkg::MODE_VECTOR;
			end else if (c.act == vtpe_pkg::ACT_POINT) begin
				if (term_mode != vtpe_pkg::MODE_POINT) begin
					bytes.push_back(vtpe_pkg::B_FS);
					term_mode = vtpe_pkg::MODE_POINT;
				end
			end else if (c.act == vtpe_pkg::ACT_IPOINT) begin
				if (term_mode != vtpe_pkg::MODE_IPOINT) begin
					if (term_mode != vtpe_pkg::MODE_TEXT)
						bytes.push_back(vtpe_pkg::B_US);
					bytes.push_back(vtpe_pkg::B_ESC);
					bytes.push_back(vtpe_pkg::B_FS);
					term_mode = vtpe_pkg::MODE_IPOINT;
				end
				if (level > vtpe_pkg::INTEN_MAX)
					level = vtpe_pkg::INTEN_MAX;
				if (level < vtpe_pkg::INTEN_MIN)
					level = vtpe_pkg::INTEN_MIN;
				bytes.push_back(level);
			end
			// address bytes, each tagged by its top bits
			lo_x = {2'b10, x[6:2]};
			hi_x = {2'b01, x[11:7]};
			lo_y = {2'b11, y[6:2]};
			hi_y = {2'b01, y[11:7]};
			extra = {2'b11, y[12], y[1:0], x[1:0]};
			// a new hi x leaves the lo y slot stale, so lo y goes out with it
			if (sent_hx != hi_x) begin
				snd_hx = 1;
				sent_hx = hi_x;
				sent_ly = hi_x;
			end
			if (sent_ex != extra) begin
				snd_ex = 1;
				snd_ly = 1;
				sent_ex = extra;
				sent_ly = lo_y;
			end else if (sent_ly != lo_y) begin
				snd_ly = 1;
				sent_ly = lo_y;
			end
			if (sent_hy != hi_y) begin
				snd_hy = 1;
				sent_hy = hi_y;
			end
			if (snd_hy)
				bytes.push_back({1'b0, hi_y});
			if (snd_ex)
				bytes.push_back({1'b0, extra});
			if (snd_ly)
				bytes.push_back({1'b0, lo_y});
			if (snd_hx)
				bytes.push_back({1'b0, hi_x});
			bytes.push_back({1'b0, lo_x});
			// a long vector forgets the sent address
			if (jump_en) begin
				if ((abs_diff(x, int'(prev_x)) > int'(vtpe_pkg::JUMP_LIMIT) ||
						abs_diff(y, int'(prev_y)) > int'(vtpe_pkg::JUMP_LIMIT)) &&
						term_mode == vtpe_pkg::MODE_VECTOR) begin
					sent_hy = '0;
					sent_ly = '0;
					sent_hx = '0;
					sent_ex = '0;
				end
				prev_x = x[12:0];
				prev_y = y[12:0];
			end
		end else if (c.act == vtpe_pkg::ACT_TEXT) begin
			if (jump_en && term_mode == vtpe_pkg::MODE_VECTOR)
				repeat (4) bytes.push_back(vtpe_pkg::B_NUL);
			term_mode = vtpe_pkg::MODE_TEXT;
			prev_x = -13'sd1;
			prev_y = -13'sd1;
			bytes.push_back(vtpe_pkg::B_US);
		end else if (c.act == vtpe_pkg::ACT_PAGE) begin
			sent_hy = '0;
			sent_ly = '0;
			sent_hx = '0;
			sent_ex = '0;
			prev_x = -13'sd1;
			prev_y = -13'sd1;
			bytes.push_back(vtpe_pkg::B_ESC);
			bytes.push_back(vtpe_pkg::B_FF);
			term_mode = vtpe_pkg::MODE_TEXT;
		end
		foreach (bytes[i]) begin
			tb.data = bytes[i];
			tb.last = (i == bytes.size() - 1);
			expected_bytes.push_back(tb);
		end
	endtask

	// slave-side driver: holds a word until taken, idles at random between words
	always @(posedge clk) begin : cmd_driver
		plot_cmd_t next_cmd;
		bit holding;
		if (arst_n) begin
			holding = s_tvalid && !s_tready;
			if (s_tvalid && s_tready)
				encode_command(plot_cmd_t'({s_tuser, s_tdata[7:0], s_tdata[21:8],
					s_tdata[35:22]}));
			if (!holding) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, next_cmd.y, next_cmd.x, next_cmd.level};
					s_tuser <= next_cmd.act;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// master-side receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin : byte_receiver
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				long_holds_done <= long_holds_done + 1;
		end else if (long_holds_done != long_holds_asked) begin
			m_tready <= 1'b0;
			hold_left <= LONG_HOLD;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare every taken byte with the oldest expected one
	always @(posedge clk) begin : byte_monitor
		term_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual data %02h last %0b",
					$time, m_tdata, m_tlast);
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data) begin
					errors++;
					$display("%0t: data mismatch: expected %02h, actual %02h",
						$time, want.data, m_tdata);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want.last, m_tlast);
				end
			end
		end
	end

	function automatic plot_cmd_t make_cmd(logic [2:0] act, int x, int y, logic [7:0] level);
		plot_cmd_t c;
		c.act = act;
		c.level = level;
		c.x = x[13:0];
		c.y = y[13:0];
		return c;
	endfunction

	function automatic int clamp_coord(int v);
		if (v < 0)
			return 0;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	// register write; only called with nothing in flight
	task automatic write_jump_enable(input bit v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		jump_en = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// wait until every command is taken and every byte has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || expected_bytes.size() != 0);
		// margin after the last byte before the next phase
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_directed();
		// first address from reset goes out in full, then the far corner
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_DRAW, 0, 0, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_DRAW, COORD_MAX, COORD_MAX, 8'h00));
		// dark moves, both long jumps
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_MOVE, COORD_MAX, 0, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_MOVE, 0, COORD_MAX, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_DRAW, 0, COORD_MAX, 8'h00));
		// text from vector mode, padded when jump reset is on
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_TEXT, 0, 0, 8'h00));
		// points: extra with lo y twice, then lo y only, then a hi x change that drags lo y along
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_POINT, 100, 200, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_POINT, 101, 200, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_POINT, 101, 204, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_POINT, 228, 204, 8'h00));
		// move out of point mode needs US first
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_MOVE, 2000, 2000, 8'h00));
		// intensity clamping at both ends
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 2000, 2000, 8'd0));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 2001, 2000, 8'd255));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 2001, 2001, 8'd31));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 2002, 2001, 8'd126));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_POINT, 2002, 2002, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 2003, 2002, 8'd32));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 2003, 2003, 8'd125));
		// intensity point straight from text mode has no US
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_TEXT, 0, 0, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 10, 4000, 8'd77));
		// new page clears the sent address
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_PAGE, 0, 0, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_DRAW, 10, 10, 8'h00));
		// off-screen points and spare codes give nothing
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_DRAW, -1, 10, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_POINT, COORD_MAX + 1, 10, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_MOVE, 10, -8192, 8'h00));
		pending_cmds.push_back(make_cmd(vtpe_pkg::ACT_IPOINT, 8191, 8191, 8'hFF));
		pending_cmds.push_back(make_cmd(ACT_SPARE_A, 10, 10, 8'h00));
		pending_cmds.push_back(make_cmd(ACT_SPARE_B, 10, 10, 8'h00));
	endtask

	// mostly on-screen plotting around a wandering cursor, some raw noise
	task automatic queue_random(input int n);
		int queued, pick;
		logic [2:0] act;
		queued = 0;
		while (queued < n) begin
			if ($urandom_range(99) < 10) begin
				// raw words: any code, any coordinates, mostly off screen
				pending_cmds.push_back(make_cmd(3'($urandom_range(7)),
					int'($signed(14'($urandom))), int'($signed(14'($urandom))),
					8'($urandom)));
			end else begin
				pick = $urandom_range(9);
				if (pick < 6) begin
					// short step keeps most high bytes unchanged
					walk_x = clamp_coord(walk_x + $urandom_range(80) - 40);
					walk_y = clamp_coord(walk_y + $urandom_range(80) - 40);
				end else if (pick < 9) begin
					walk_x = $urandom_range(COORD_MAX);
					walk_y = $urandom_range(COORD_MAX);
				end else begin
					walk_x = $urandom_range(1) ? COORD_MAX : 0;
					walk_y = $urandom_range(1) ? COORD_MAX : 0;
				end
				pick = $urandom_range(99);
				if (pick < 30)
					act = vtpe_pkg::ACT_DRAW;
				else if (pick < 50)
					act = vtpe_pkg::ACT_MOVE;
				else if (pick < 65)
					act = vtpe_pkg::ACT_POINT;
				else if (pick < 82)
					act = vtpe_pkg::ACT_IPOINT;
				else if (pick < 93)
					act = vtpe_pkg::ACT_TEXT;
				else
					act = vtpe_pkg::ACT_PAGE;
				pending_cmds.push_back(make_cmd(act, walk_x, walk_y, 8'($urandom)));
			end
			queued++;
		end
	endtask

	// sequencer
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		write_jump_enable(1'b0);
		@(negedge clk);
		send_idle_pct = 34;
		recv_idle_pct = 84;
		queue_directed();
		wait_drained();

		write_jump_enable(1'b1);
		@(negedge clk);
		queue_directed();
		wait_drained();

		@(negedge clk);
		queue_random(130);
		wait_drained();

		// roles swapped, jump reset off
		write_jump_enable(1'b0);
		@(negedge clk);
		send_idle_pct = 84;
		recv_idle_pct = 34;
		queue_random(130);
		wait_drained();

		// full speed, with one long receiver hold-off to back up the input
		write_jump_enable(1'b1);
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(144);
		long_holds_asked++;
		wait_drained();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: vector_terminal_plot_encoder.f
hw/rtl/vtpe_pkg.sv
hw/rtl/vtpe_front.sv
hw/rtl/vtpe_queue.sv
hw/rtl/vtpe_back.sv
hw/rtl/vector_terminal_plot_encoder.sv
hw/rtl/vtpe_checker.sv
bench/vector_terminal_plot_encoder_tb.sv
